FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue: action and status
// codes, time widths, timeout limits and the controller/datapath interface.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam int NS_W  = 63;
  localparam int TMO_W = 31;

  // action codes
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_DEL  = 2'd1;
  localparam logic [1:0] ACT_EXEC = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // timeout limits
  localparam logic [NS_W-1:0]  CAP_NS = NS_W'(64'd2147000000000);
  localparam logic [TMO_W-1:0] CAP_US = TMO_W'(32'd2147000000);

  // ns to us rounding: (diff + 999) / 1000 is worked as ((diff + 999) >> 3) / 125
  // by a reciprocal multiply in four partial products; dividend below 2^41
  localparam int DIV_W     = 41;
  localparam int PART_W    = 19;
  localparam int ACC_W     = 77;
  localparam int RECIP_SH  = 45;
  localparam int DIV_STEPS = 4;
  localparam int DCNT_W    = 3;
  localparam logic [DIV_W-1:0]  ROUND_NS = 41'd999;
  localparam logic [2*PART_W:0] RECIP_US = 39'd281474976711;

  // controller commands
  typedef struct packed {
    logic    load_in;
    logic    sel_q;
    logic    p_clr;
    logic    p_inc;
    logic    q_clr;
    logic    q_inc;
    logic    fires_clr;
    logic    add_wr;
    logic    ins;
    logic    del_clr;
    logic    drop;
    logic    fire;
    logic    tmo_diff;
    logic    tmo_set;
    logic    div_step;
    logic    emit_final;
    status_t code;
    logic    use_tmo;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic [1:0] act;
    logic       zero_timer;
    logic       full;
    logic       p_end;
    logic       ins_go;
    logic       del_hit;
    logic       cur_live;
    logic       not_due;
    logic       has_period;
    logic       need_div;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer of the timer queue: decodes the action and steps the datapath
// through scans, inserts, firings and the timeout computation.
// ----------------------------------------------------------------------------
module stq_ctrl import stq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RESULT, S_ADD_WR, S_INS_SCAN, S_DEL_SCAN,
    S_EX_LOOK, S_FIRE, S_TMO_A, S_TMO_B, S_DIV
  } state_t;

  state_t  state, state_next;
  status_t res_code, res_code_next;
  logic    use_tmo, use_tmo_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    use_tmo_next  = use_tmo;
    cmd           = '0;
    cmd.code      = res_code;
    cmd.use_tmo   = use_tmo;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_code_next = ST_OK;
        use_tmo_next  = 1'b0;
        case (sts.act)
          ACT_ADD: begin
            if (sts.zero_timer) begin
              res_code_next = ST_ZERO;
              state_next    = S_RESULT;
            end else if (sts.full) begin
              res_code_next = ST_FULL;
              state_next    = S_RESULT;
            end else begin
              state_next = S_ADD_WR;
            end
          end
          ACT_DEL: begin
            cmd.p_clr  = 1'b1;
            state_next = S_DEL_SCAN;
          end
          ACT_EXEC: begin
            cmd.p_clr     = 1'b1;
            cmd.fires_clr = 1'b1;
            state_next    = S_EX_LOOK;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        cmd.q_clr  = 1'b1;
        state_next = S_INS_SCAN;
      end
      // find the place after all equal or earlier entries
      S_INS_SCAN: begin
        cmd.sel_q = 1'b1;
        if (sts.ins_go) begin
          cmd.q_inc = 1'b1;
        end else begin
          cmd.ins = 1'b1;
          if (sts.act == ACT_ADD) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_EX_LOOK;
          end
        end
      end
      S_DEL_SCAN: begin
        if (sts.p_end) begin
          res_code_next = ST_NOT_FOUND;
          state_next    = S_RESULT;
        end else if (sts.del_hit) begin
          cmd.del_clr = 1'b1;
          state_next  = S_RESULT;
        end else begin
          cmd.p_inc = 1'b1;
        end
      end
      // walk: drop marked entries, stop at the list end, at the first entry not due or at the fire cap
      S_EX_LOOK: begin
        if (sts.p_end) begin
          cmd.p_clr  = 1'b1;
          state_next = S_TMO_A;
        end else if (!sts.cur_live) begin
          cmd.drop = 1'b1;
        end else if (sts.not_due) begin
          cmd.p_clr  = 1'b1;
          state_next = S_TMO_A;
        end else begin
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        if (sts.out_free) begin
          cmd.fire = 1'b1;
          if (sts.has_period) begin
            cmd.q_clr  = 1'b1;
            state_next = S_INS_SCAN;
          end else begin
            state_next = S_EX_LOOK;
          end
        end
      end
      S_TMO_A: begin
        cmd.tmo_diff = 1'b1;
        state_next   = S_TMO_B;
      end
      S_TMO_B: begin
        cmd.tmo_set  = 1'b1;
        use_tmo_next = 1'b1;
        if (sts.need_div) begin
          state_next = S_DIV;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_RESULT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= ST_OK;
      use_tmo  <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      use_tmo  <= use_tmo_next;
    end
  end

endmodule

FILE: rtl/stq_dp.sv
// ----------------------------------------------------------------------------
// stq_dp
// Datapath of the timer queue: timer table, sorted order list, walk
// pointers, timeout divider and the output word register.
// ----------------------------------------------------------------------------
module stq_dp import stq_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         action,
  input  logic [ID_BITS-1:0] timer_id,
  input  logic [NS_W-1:0]    first_delay_ns,
  input  logic [NS_W-1:0]    period_ns,
  input  logic [NS_W-1:0]    now_ns,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               is_fire,
  output logic [ID_BITS-1:0] fired_id,
  output logic [TMO_W-1:0]   next_timeout_us,
  output logic               last
);

  localparam int SLOT_W   = $clog2(TIMER_SLOTS);
  localparam int CNT_W    = $clog2(TIMER_SLOTS + 1);
  localparam int FIRE_CAP = 2 * TIMER_SLOTS;
  localparam int FIRE_W   = $clog2(FIRE_CAP + 1);

  // latched input word
  logic [1:0]         act_r;
  logic [ID_BITS-1:0] id_r;
  logic [NS_W-1:0]    delay_r, period_r, now_r;

  // timer table and order list
  logic [NS_W-1:0]    entry_expiry [TIMER_SLOTS];
  logic [NS_W-1:0]    entry_period [TIMER_SLOTS];
  logic [ID_BITS-1:0] entry_id     [TIMER_SLOTS];
  logic               entry_live   [TIMER_SLOTS];
  logic [SLOT_W-1:0]  order_slots  [TIMER_SLOTS];

  logic [CNT_W-1:0]   count, p, q;
  logic [FIRE_W-1:0]  fires;
  logic [SLOT_W-1:0]  cur_slot;
  logic [NS_W-1:0]    cur_exp;
  logic               head_empty, head_past;
  logic [NS_W-1:0]    head_diff;
  logic [TMO_W-1:0]   dv;
  logic [DCNT_W-1:0]  div_cnt;

  logic [SLOT_W-1:0]  p_slot, q_slot, rd_slot, free_slot;
  logic [NS_W-1:0]    rd_exp, rd_period;
  logic [ID_BITS-1:0] rd_id;
  logic               rd_live;
  logic [NS_W:0]      add_sum, fire_sum;
  logic [NS_W-1:0]    add_sat, fire_sat, fire_new;
  logic [TIMER_SLOTS-1:0] used;
  logic [DIV_W-1:0]   dv_sum;
  logic [2*PART_W-1:0] dq;
  logic [PART_W-1:0]  mul_a;
  logic [PART_W:0]    mul_b;
  logic [2*PART_W:0]  mul_p;
  logic [ACC_W-1:0]   acc, acc_sum, pp_sh;

  // table read port
  assign p_slot    = order_slots[p[SLOT_W-1:0]];
  assign q_slot    = order_slots[q[SLOT_W-1:0]];
  assign rd_slot   = cmd.sel_q ? q_slot : p_slot;
  assign rd_exp    = entry_expiry[rd_slot];
  assign rd_period = entry_period[rd_slot];
  assign rd_id     = entry_id[rd_slot];
  assign rd_live   = entry_live[rd_slot];

  // saturating expiry sums
  assign add_sum  = {1'b0, now_r} + {1'b0, (delay_r != '0) ? delay_r : period_r};
  assign add_sat  = add_sum[NS_W] ? '1 : add_sum[NS_W-1:0];
  assign fire_sum = {1'b0, rd_exp} + {1'b0, rd_period};
  assign fire_sat = fire_sum[NS_W] ? '1 : fire_sum[NS_W-1:0];
  assign fire_new = (fire_sat < now_r) ? now_r : fire_sat;

  // lowest slot not named in the order list
  always_comb begin
    used      = '0;
    free_slot = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (CNT_W'(i) < count) used[order_slots[i]] = 1'b1;
    end
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) free_slot = SLOT_W'(i);
    end
  end

  // reciprocal multiply: one partial product per step, low halves first
  assign dv_sum  = head_diff[DIV_W-1:0] + ROUND_NS;
  assign mul_a   = (div_cnt <= DCNT_W'(2)) ? dq[2*PART_W-1:PART_W] : dq[PART_W-1:0];
  assign mul_b   = div_cnt[0] ? RECIP_US[2*PART_W:PART_W] : {1'b0, RECIP_US[PART_W-1:0]};
  assign mul_p   = (2*PART_W+1)'(mul_a) * (2*PART_W+1)'(mul_b);
  assign pp_sh   = (div_cnt == DCNT_W'(DIV_STEPS)) ? ACC_W'(mul_p) :
                   (div_cnt == DCNT_W'(1)) ? (ACC_W'(mul_p) << (2*PART_W)) :
                   (ACC_W'(mul_p) << PART_W);
  assign acc_sum = acc + pp_sh;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.act        = act_r;
    sts.zero_timer = (delay_r == '0) && (period_r == '0);
    sts.full       = (count >= CNT_W'(TIMER_SLOTS));
    sts.p_end      = (p >= count);
    sts.ins_go     = (q < count) && (rd_exp <= cur_exp);
    sts.del_hit    = rd_live && (rd_id == id_r);
    sts.cur_live   = rd_live;
    sts.not_due    = (now_r < rd_exp) || (fires >= FIRE_W'(FIRE_CAP));
    sts.has_period = (rd_period != '0);
    sts.need_div   = !head_empty && !head_past && (head_diff < CAP_NS);
    sts.div_done   = (div_cnt == '0);
    sts.out_free   = !out_valid || out_ready;
  end

  // input latch, table and order list
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r    <= action;
      id_r     <= timer_id;
      delay_r  <= first_delay_ns;
      period_r <= period_ns;
      now_r    <= now_ns;
    end
    if (cmd.add_wr) begin
      entry_expiry[free_slot] <= add_sat;
      entry_period[free_slot] <= period_r;
      entry_id[free_slot]     <= id_r;
      entry_live[free_slot]   <= 1'b1;
      cur_slot                <= free_slot;
      cur_exp                 <= add_sat;
    end
    if (cmd.del_clr) begin
      entry_live[rd_slot]   <= 1'b0;
      entry_id[rd_slot]     <= '0;
      entry_expiry[rd_slot] <= '0;
      entry_period[rd_slot] <= '0;
    end
    if (cmd.fire) begin
      cur_slot <= rd_slot;
      cur_exp  <= fire_new;
      if (rd_period != '0) begin
        entry_expiry[rd_slot] <= fire_new;
      end else begin
        entry_live[rd_slot]   <= 1'b0;
        entry_expiry[rd_slot] <= '0;
      end
    end
    // remove at p: close the gap
    if (cmd.drop || cmd.fire) begin
      for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
        if (CNT_W'(i) >= p) order_slots[i] <= order_slots[i+1];
      end
    end
    // insert at q: open a gap
    if (cmd.ins) begin
      for (int i = 1; i < TIMER_SLOTS; i++) begin
        if (CNT_W'(i) > q) order_slots[i] <= order_slots[i-1];
      end
      order_slots[q[SLOT_W-1:0]] <= cur_slot;
    end
    // head timeout
    if (cmd.tmo_diff) begin
      head_empty <= (count == '0);
      head_past  <= (rd_exp < now_r);
      head_diff  <= rd_exp - now_r;
    end
    if (cmd.tmo_set) begin
      acc <= '0;
      dq  <= dv_sum[DIV_W-1:3];
      if (head_empty) begin
        dv <= CAP_US;
      end else if (head_past) begin
        dv <= '0;
      end else begin
        dv <= CAP_US;
      end
    end
    if (cmd.div_step) begin
      acc <= acc_sum;
      if (div_cnt == DCNT_W'(1)) begin
        dv <= acc_sum[RECIP_SH+TMO_W-1:RECIP_SH];
      end
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      p       <= '0;
      q       <= '0;
      fires   <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.ins) begin
        count <= count + 1'b1;
      end else if (cmd.drop || cmd.fire) begin
        count <= count - 1'b1;
      end
      if (cmd.p_clr) begin
        p <= '0;
      end else if (cmd.p_inc || (cmd.ins && act_r == ACT_EXEC && q <= p)) begin
        p <= p + 1'b1;
      end
      if (cmd.q_clr) begin
        q <= '0;
      end else if (cmd.q_inc) begin
        q <= q + 1'b1;
      end
      if (cmd.fires_clr) begin
        fires <= '0;
      end else if (cmd.fire) begin
        fires <= fires + 1'b1;
      end
      if (cmd.tmo_set) begin
        div_cnt <= sts.need_div ? DCNT_W'(DIV_STEPS) : '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_final || cmd.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      status          <= ST_OK;
      is_fire         <= 1'b1;
      fired_id        <= rd_id;
      next_timeout_us <= '0;
      last            <= 1'b0;
    end else if (cmd.emit_final) begin
      status          <= cmd.code;
      is_fire         <= 1'b0;
      fired_id        <= '0;
      next_timeout_us <= cmd.use_tmo ? dv : '0;
      last            <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TIMER_SLOTS))
    else $error("entry count above table size");
  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fires <= FIRE_W'(FIRE_CAP))
    else $error("fire count above cap");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire || cmd.emit_final) |-> (!out_valid || out_ready))
    else $error("result word overwritten while pending");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> (count < CNT_W'(TIMER_SLOTS)) && (q <= count))
    else $error("insert without room");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_cnt != '0))
    else $error("divider stepped past its end");
`endif

endmodule

FILE: rtl/sorted_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Timer table kept sorted by expiry with add, delete and execute actions.
// ----------------------------------------------------------------------------
// One input word is worked at a time; in_ready is high only while idle, and
// a pending result word does not hold up the next input. Add scans the order
// list past the entries at or before the new expiry, delete scans it up to
// the match, and the scans and the dropping of marked entries go one entry
// per cycle. Execute drops or fires each due entry, with a reinsert scan per
// periodic firing, then works out the head timeout and, when the head is
// ahead of now, the ns to us rounding multiply. Firing words wait on out_ready
// before the walk goes on. Results come out one word per handshake, the final
// one with last set.
module sorted_timer_queue_unit import stq_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [ID_BITS-1:0] timer_id,
  input  logic [NS_W-1:0]    first_delay_ns,
  input  logic [NS_W-1:0]    period_ns,
  input  logic [NS_W-1:0]    now_ns,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               is_fire,
  output logic [ID_BITS-1:0] fired_id,
  output logic [TMO_W-1:0]   next_timeout_us,
  output logic               last
);

  cmd_t cmd;
  sts_t sts;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stq_dp #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .action          (action),
    .timer_id        (timer_id),
    .first_delay_ns  (first_delay_ns),
    .period_ns       (period_ns),
    .now_ns          (now_ns),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .is_fire         (is_fire),
    .fired_id        (fired_id),
    .next_timeout_us (next_timeout_us),
    .last            (last)
  );

endmodule
